// ----- rtl/npcs_pkg.sv -----
package npcs_pkg;

  localparam int PALETTE_SIZE = 256;
  localparam int IDX_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
  localparam int CMP_W = (IDX_W > 8) ? IDX_W : 8;
  localparam int DIST_W = 18;
  localparam int IN_W = 40;
  localparam int OUT_W = 32;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_LIGHT = 2'd2;

  localparam logic [7:0] TRANS_RESET = 8'd247;
  localparam logic [11:0] LIGHT_MUL = 12'd13;
  localparam logic [7:0] LIGHT_ADD = 8'd48;

  typedef struct packed {
    logic              valid;
    logic              is_write;
    logic [7:0]        idx;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              cand_ok;
    logic [DIST_W-1:0] cand_dist;
    logic [IDX_W-1:0]  cand_idx;
    logic              best_found;
    logic [DIST_W-1:0] best_sq;
    logic [IDX_W-1:0]  best_idx;
  } item_t;

  function automatic logic [7:0] lighten(input logic [7:0] c);
    logic [11:0] p;
    p = {4'b0, c} * LIGHT_MUL;
    return p[11:4] + LIGHT_ADD;
  endfunction

  function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return {8'b0, d} * {8'b0, d};
  endfunction

  function automatic logic [DIST_W-1:0] sq_dist(input logic [7:0] r0, input logic [7:0] g0,
                                                input logic [7:0] b0, input logic [23:0] e);
    return DIST_W'(sq_diff(r0, e[23:16])) + DIST_W'(sq_diff(g0, e[15:8]))
         + DIST_W'(sq_diff(b0, e[7:0]));
  endfunction

  function automatic logic better(input item_t it);
    return it.valid && !it.is_write && it.cand_ok
        && (!it.best_found || (it.cand_dist < it.best_sq));
  endfunction

endpackage

// ----- rtl/npcs_front.sv -----
module npcs_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [npcs_pkg::IN_W-1:0]        in_data,
  output npcs_pkg::item_t                  item
);

  logic [1:0] cmd;
  logic       light;

  assign cmd = in_data[1:0];
  assign light = (cmd == npcs_pkg::CMD_LIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (en) begin
      item.valid <= in_valid;
    end
    if (en) begin
      item.is_write   <= (cmd == npcs_pkg::CMD_WRITE);
      item.idx        <= in_data[9:2];
      item.red        <= light ? npcs_pkg::lighten(in_data[17:10]) : in_data[17:10];
      item.green      <= light ? npcs_pkg::lighten(in_data[25:18]) : in_data[25:18];
      item.blue       <= light ? npcs_pkg::lighten(in_data[33:26]) : in_data[33:26];
      item.cand_ok    <= 1'b0;
      item.cand_dist  <= '0;
      item.cand_idx   <= '0;
      item.best_found <= 1'b0;
      item.best_sq    <= '0;
      item.best_idx   <= '0;
    end
  end

endmodule

// ----- rtl/npcs_cell.sv -----
module npcs_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic [npcs_pkg::IDX_W-1:0]     cell_index,
  input  logic [7:0]                     trans_index,
  input  npcs_pkg::item_t                item_in,
  output npcs_pkg::item_t                item_out
);

  logic [23:0] entry;
  logic        take;
  logic        hit;

  assign take = npcs_pkg::better(item_in);
  assign hit  = npcs_pkg::CMP_W'(item_in.idx) == npcs_pkg::CMP_W'(cell_index);

  always_ff @(posedge clk) begin
    if (en && item_in.valid && item_in.is_write && hit) begin
      entry <= {item_in.red, item_in.green, item_in.blue};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_out.valid <= 1'b0;
    end else if (en) begin
      item_out.valid <= item_in.valid;
    end
    if (en) begin
      item_out.is_write   <= item_in.is_write;
      item_out.idx        <= item_in.idx;
      item_out.red        <= item_in.red;
      item_out.green      <= item_in.green;
      item_out.blue       <= item_in.blue;
      item_out.cand_ok    <= npcs_pkg::CMP_W'(trans_index) != npcs_pkg::CMP_W'(cell_index);
      item_out.cand_dist  <= npcs_pkg::sq_dist(item_in.red, item_in.green, item_in.blue, entry);
      item_out.cand_idx   <= cell_index;
      item_out.best_found <= item_in.best_found | take;
      item_out.best_sq    <= take ? item_in.cand_dist : item_in.best_sq;
      item_out.best_idx   <= take ? item_in.cand_idx : item_in.best_idx;
    end
  end

endmodule

// ----- rtl/npcs_tail.sv -----
module npcs_tail (
  input  logic                         clk,
  input  logic                         rst,
  input  npcs_pkg::item_t              item_in,
  output logic                         en,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [npcs_pkg::OUT_W-1:0]   out_data
);

  logic                          take;
  logic                          found;
  logic [npcs_pkg::DIST_W-1:0]   chosen_sq;
  logic [npcs_pkg::IDX_W-1:0]    best;
  logic [7:0]                    color;

  assign en        = !out_valid || out_ready;
  assign take      = npcs_pkg::better(item_in);
  assign found     = item_in.best_found | take;
  assign chosen_sq = take ? item_in.cand_dist : item_in.best_sq;
  assign best      = take ? item_in.cand_idx : item_in.best_idx;
  assign color     = npcs_pkg::CMP_W'(best) & npcs_pkg::CMP_W'(8'hFF);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= item_in.valid;
    end
    if (en) begin
      if (item_in.is_write) begin
        out_data <= {6'b0, {npcs_pkg::DIST_W{1'b0}}, item_in.idx};
      end else if (found) begin
        out_data <= {6'b0, chosen_sq, color};
      end else begin
        out_data <= '0;
      end
    end
  end

endmodule

// ----- rtl/nearest_palette_color_search_top.sv -----
// Nearest palette color search.
// Input stream s_*: each request is a palette write (cmd 0), a nearest-color
// query (cmd 1 or 3) or a lightened query (cmd 2) that maps each channel c to
// c*13/16+48 before searching. Output stream m_*: one result per request,
// holding the nearest palette index and its squared distance, or the written
// index with distance zero for writes. The transparent index is skipped and
// ties go to the lowest index.
// The cfg port writes the transparent index; it is always ready and should be
// written only while no request is in flight. Reset sets it to 247.
// The search is a systolic chain with one cell per palette entry, each holding its
// entry. Unless the chain holds, each cell compares one candidate per cycle and one
// request is taken every cycle. A request passes through the front register, every
// cell and the tail register. Writes travel down the same chain, so every query sees
// exactly the writes that came before it. Reset empties the pipeline; palette entries
// hold garbage until written. When m_tready is low with a result waiting, the whole
// chain holds and s_tready drops; nothing is lost.
module nearest_palette_color_search_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [npcs_pkg::IN_W-1:0]       s_tdata,  // cmd, entry_index, red, green, blue
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [npcs_pkg::OUT_W-1:0]      m_tdata,  // color_index, best_distance
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [7:0]                      cfg_data
);

  logic             en;
  logic [7:0]       trans_index;
  npcs_pkg::item_t  chain [npcs_pkg::PALETTE_SIZE+1];

  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trans_index <= npcs_pkg::TRANS_RESET;
    end else if (cfg_valid) begin
      trans_index <= cfg_data;
    end
  end

  npcs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .in_data  (s_tdata),
    .item     (chain[0])
  );

  for (genvar k = 0; k < npcs_pkg::PALETTE_SIZE; k++) begin : g_cell
    npcs_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .en          (en),
      .cell_index  (npcs_pkg::IDX_W'(k)),
      .trans_index (trans_index),
      .item_in     (chain[k]),
      .item_out    (chain[k+1])
    );
  end

  npcs_tail u_tail (
    .clk       (clk),
    .rst       (rst),
    .item_in   (chain[npcs_pkg::PALETTE_SIZE]),
    .en        (en),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
